/* rtl/deq_pkg.sv */
// Shared types and codes for the deduplicating event ring queue.
package deq_pkg;

   localparam int unsigned IdWidth        = 32;
   localparam int unsigned OccupancyWidth = 3;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      STATUS_STORED       = 3'd0,
      STATUS_STORED_EVICT = 3'd1,
      STATUS_ZERO_ID      = 3'd2,
      STATUS_DUPLICATE    = 3'd3,
      STATUS_DELIVERED    = 3'd4,
      STATUS_EMPTY        = 3'd5
   } status_type;

   typedef struct packed {
      op_type               operation;
      logic [IdWidth-1:0]   event_id;
      logic                 event_flag;
   } req_type;

   typedef struct packed {
      status_type                  status;
      logic [IdWidth-1:0]          out_event_id;
      logic                        out_event_flag;
      logic [OccupancyWidth-1:0]   occupancy;
   } rsp_type;

   typedef struct packed {
      logic [IdWidth-1:0] id;
      logic               flag;
   } entry_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctl_type;

endpackage

/* rtl/deq_cell.sv */
// One queue cell: holds one event record, shifts toward the head, compares its identifier.
module deq_cell
   import deq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cell_ctl_type       ctl,
   input  entry_type          load_entry,
   input  entry_type          right_entry,
   input  logic               right_valid,
   input  logic [IdWidth-1:0] cmp_id,
   output entry_type          entry,
   output logic               valid,
   output logic               match
);

   entry_type entry_ff, entry_in;
   logic      valid_ff, valid_in;

   // A load has priority: on an eviction the last cell shifts and loads at once.
   always_comb begin
      priority if (ctl.load) begin
         entry_in = load_entry;
         valid_in = 1'b1;
      end else if (ctl.shift) begin
         entry_in = right_entry;
         valid_in = right_valid;
      end else begin
         entry_in = entry_ff;
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign entry = entry_ff;
   assign valid = valid_ff;
   assign match = valid_ff && (entry_ff.id == cmp_id);

endmodule

/* rtl/dedup_event_ring_queue.sv */
// Top level of the deduplicating event queue: control, cell row and response register.
//
//   Channel   Ports                           Direction  Transfer when
//   request   start, busy, req_item           in         start high and busy low at a clock edge
//   response  rsp_valid, rsp_item             out        every cycle in which rsp_valid is high
//
// For every access the request is decoded and the whole cell row is updated at the
// accepting edge, and the response appears in the following cycle.
// A new request may be taken in every cycle; busy is held low.
// Reset is synchronous and clears the occupancy count, all cell valid bits and the
// response strobe; the stored records themselves are not cleared.
// The receiver cannot stall: each response is shown for exactly one cycle.
module dedup_event_ring_queue
   import deq_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   localparam int unsigned CountWidth = $clog2(QUEUE_DEPTH + 1);

   // The queue is kept compacted: cell 0 holds the oldest record, and cells
   // 0 .. count-1 are valid. A dequeue or an eviction shifts the row one cell
   // toward the head; a store loads the first free cell, or the last cell when
   // the row is full and has just shifted.
   logic [CountWidth-1:0]  count_ff, count_in;
   rsp_type                rsp_ff, rsp_in;
   logic                   rsp_valid_ff;

   cell_ctl_type           cell_ctl   [QUEUE_DEPTH];
   entry_type              cell_entry [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0] cell_valid;
   logic [QUEUE_DEPTH-1:0] cell_match;

   logic                   accept;
   logic                   is_enqueue;
   logic                   zero_id;
   logic                   duplicate;
   logic                   full;
   logic                   empty;
   logic                   store;
   logic                   shift;
   logic [CountWidth-1:0]  load_slot;
   entry_type              new_entry;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign is_enqueue = (req_item.operation == OP_ENQUEUE);
   assign zero_id    = (req_item.event_id == '0);
   assign duplicate  = |cell_match;
   assign full       = (count_ff == CountWidth'(QUEUE_DEPTH));
   assign empty      = (count_ff == '0);

   // The zero check comes before the duplicate check, and a duplicate is refused
   // even on a full queue, so nothing is evicted for it.
   assign store = accept && is_enqueue && !zero_id && !duplicate;
   assign shift = (store && full) || (accept && !is_enqueue && !empty);

   assign load_slot = full ? CountWidth'(QUEUE_DEPTH - 1) : count_ff;

   assign new_entry.id   = req_item.event_id;
   assign new_entry.flag = req_item.event_flag;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type right_entry;
      logic      right_valid;

      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign right_entry = '0;
         assign right_valid = 1'b0;
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
         assign right_valid = cell_valid[i+1];
      end

      assign cell_ctl[i].shift = shift;
      assign cell_ctl[i].load  = store && (load_slot == CountWidth'(i));

      deq_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (cell_ctl[i]),
         .load_entry  (new_entry),
         .right_entry (right_entry),
         .right_valid (right_valid),
         .cmp_id      (req_item.event_id),
         .entry       (cell_entry[i]),
         .valid       (cell_valid[i]),
         .match       (cell_match[i])
      );
   end

   // Count update and response formation. The occupancy in the response is the
   // count after this access.
   always_comb begin
      count_in               = count_ff;
      rsp_in.status          = STATUS_EMPTY;
      rsp_in.out_event_id    = '0;
      rsp_in.out_event_flag  = 1'b0;
      if (accept) begin
         if (is_enqueue) begin
            priority if (zero_id) begin
               rsp_in.status = STATUS_ZERO_ID;
            end else if (duplicate) begin
               rsp_in.status = STATUS_DUPLICATE;
            end else if (full) begin
               rsp_in.status = STATUS_STORED_EVICT;
            end else begin
               rsp_in.status = STATUS_STORED;
               count_in      = count_ff + 1'b1;
            end
         end else begin
            if (empty) begin
               rsp_in.status = STATUS_EMPTY;
            end else begin
               rsp_in.status         = STATUS_DELIVERED;
               rsp_in.out_event_id   = cell_entry[0].id;
               rsp_in.out_event_flag = cell_entry[0].flag;
               count_in              = count_ff - 1'b1;
            end
         end
      end
      rsp_in.occupancy = OccupancyWidth'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The number of valid cells always equals the count.
   a_valid_matches_count : assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid bits disagree with occupancy count");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(QUEUE_DEPTH))
      else $error("occupancy count exceeds queue depth");

   a_rsp_follows_accept : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(accept))
      else $error("response strobe without an accepted request");

   a_evict_keeps_full : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.status == STATUS_STORED_EVICT)
         |-> count_ff == CountWidth'(QUEUE_DEPTH))
      else $error("eviction did not leave the queue full");

   a_refused_keeps_count : assert property (@(posedge clock) disable iff (reset)
      (accept && is_enqueue && (zero_id || duplicate)) |=> $stable(count_ff))
      else $error("refused enqueue changed the occupancy");

endmodule
